/* src/ftl_pkg.sv */
// Shared constants, types and controller/datapath command and status for the flow table.
package ftl_pkg;

    localparam int ADDR_W     = 32;
    localparam int PORT_W     = 16;
    localparam int PROTO_W    = 8;
    localparam int SLOT_OUT_W = 10;
    localparam int FLOW_W     = 10;
    localparam int COUNT_W    = 11;
    localparam int HASH_MULT  = 131;

    // Key field folded into the hash in the current step
    typedef enum logic [2:0] {
        SEL_SA,
        SEL_DA,
        SEL_SP,
        SEL_DP,
        SEL_PR
    } field_sel_t;

    // One table entry as held in the entry memory
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  source_address;
        logic [ADDR_W-1:0]  destination_address;
        logic [PORT_W-1:0]  source_port_number;
        logic [PORT_W-1:0]  destination_port_number;
        logic [PROTO_W-1:0] protocol_number;
        logic [FLOW_W-1:0]  flow_number;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic       clear;
        logic       load_key;
        logic       hash_step;
        field_sel_t hash_sel;
        logic       seed;
        logic       read;
        logic       advance;
        logic       insert;
        logic       hit;
        logic       full;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic entry_valid;
        logic key_hit;
        logic probe_last;
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

/* src/ftl_key_if.sv */
// Handshake channel carrying one flow key word.
interface ftl_key_if;
    logic                        valid;
    logic                        ready;
    logic [ftl_pkg::ADDR_W-1:0]  source_address;
    logic [ftl_pkg::ADDR_W-1:0]  destination_address;
    logic [ftl_pkg::PORT_W-1:0]  source_port_number;
    logic [ftl_pkg::PORT_W-1:0]  destination_port_number;
    logic [ftl_pkg::PROTO_W-1:0] protocol_number;

    modport source (
        output valid, source_address, destination_address,
               source_port_number, destination_port_number, protocol_number,
        input  ready
    );
    modport sink (
        input  valid, source_address, destination_address,
               source_port_number, destination_port_number, protocol_number,
        output ready
    );
endinterface

/* src/ftl_res_if.sv */
// Handshake channel carrying one lookup result word.
interface ftl_res_if;
    logic                           valid;
    logic                           ready;
    logic [ftl_pkg::SLOT_OUT_W-1:0] slot_index;
    logic [ftl_pkg::FLOW_W-1:0]     flow_number;
    logic                           was_new;
    logic                           table_full;

    modport source (
        output valid, slot_index, flow_number, was_new, table_full,
        input  ready
    );
    modport sink (
        input  valid, slot_index, flow_number, was_new, table_full,
        output ready
    );
endinterface

/* src/flow_table_lookup_insert.sv */
// Flow table top level: five-tuple lookup with insert on miss, linear probing.
//
// Channels: lookup (sink) takes one five-tuple key word; result (source) gives
// slot_index, flow_number, was_new and table_full for that key. Valid/ready
// handshake on both, a word moves when valid and ready are high at a clock edge.
// Hash is h = h*131 + field over the five fields, home slot = h mod TABLE_DEPTH.
// TABLE_DEPTH must be a power of two (16 to 1024); the block does not check it.
// One key is worked at a time. After acceptance the controller runs a hash
// fold step per key field, a seed step, then a read step and a compare step
// per probed slot on the single-port entry memory; the compare step that
// ends the probe loads the result register once it is free. The next key is
// accepted in ST_IDLE, which the controller enters when the result is loaded.
// A miss writes the key to the empty slot and hands out the next flow number
// (an 11-bit counter, low 10 bits reported). If all slots are taken and none
// matches, table_full is set and nothing is stored.
// Reset: after rst_n rises the block clears the entry memory, one slot per
// cycle, for TABLE_DEPTH cycles; lookup.ready stays low meanwhile.
// A stalled result sits in the output register; the block still accepts and
// works the next key, and waits only to load its result.
module flow_table_lookup_insert #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    ftl_key_if.sink   lookup,
    ftl_res_if.source result
);

    ftl_pkg::dp_cmd_t    cmd;
    ftl_pkg::dp_status_t status;

    ftl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .lookup_valid (lookup.valid),
        .lookup_ready (lookup.ready),
        .status       (status),
        .cmd          (cmd)
    );

    ftl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cmd                     (cmd),
        .status                  (status),
        .source_address          (lookup.source_address),
        .destination_address     (lookup.destination_address),
        .source_port_number      (lookup.source_port_number),
        .destination_port_number (lookup.destination_port_number),
        .protocol_number         (lookup.protocol_number),
        .result_valid            (result.valid),
        .result_ready            (result.ready),
        .slot_index              (result.slot_index),
        .flow_number             (result.flow_number),
        .was_new                 (result.was_new),
        .table_full              (result.table_full)
    );

`ifndef ASSERT_OFF
    // At most one kind of result per lookup
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.insert, cmd.hit, cmd.full}))
        else $error("more than one result kind in one cycle");

    // A result is loaded only when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.insert || cmd.hit || cmd.full) |-> status.out_free)
        else $error("result loaded over a pending word");

    // A loaded result shows on the result channel next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.insert || cmd.hit || cmd.full) |=> result.valid)
        else $error("loaded result not presented");

    // No insert comes right after a clearing step or right after a key is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clear || (lookup.valid && lookup.ready)) |=> !cmd.insert)
        else $error("insert too early");
`endif

endmodule

/* src/ftl_ctrl.sv */
// Sequencer for the flow table: clearing pass, hash steps, probe loop, result load.
module ftl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                lookup_valid,
    output logic                lookup_ready,
    input  ftl_pkg::dp_status_t status,
    output ftl_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_SEED,
        ST_READ,
        ST_CHECK
    } state_t;

    state_t              state_reg, state_next;
    ftl_pkg::field_sel_t sel_reg, sel_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        cmd          = '0;
        cmd.hash_sel = sel_reg;
        lookup_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                lookup_ready = 1'b1;
                if (lookup_valid)
                begin
                    cmd.load_key = 1'b1;
                    sel_next     = ftl_pkg::SEL_SA;
                    state_next   = ST_HASH;
                end
            end
            ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                case (sel_reg)
                    ftl_pkg::SEL_SA: sel_next = ftl_pkg::SEL_DA;
                    ftl_pkg::SEL_DA: sel_next = ftl_pkg::SEL_SP;
                    ftl_pkg::SEL_SP: sel_next = ftl_pkg::SEL_DP;
                    ftl_pkg::SEL_DP: sel_next = ftl_pkg::SEL_PR;
                    default:         state_next = ST_SEED;
                endcase
            end
            ST_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // End on empty slot, match or full table, when out_free; else next slot
                if (!status.entry_valid || status.key_hit || status.probe_last)
                begin
                    if (status.out_free)
                    begin
                        cmd.insert = !status.entry_valid;
                        cmd.hit    = status.entry_valid && status.key_hit;
                        cmd.full   = status.entry_valid && !status.key_hit;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            sel_reg   <= ftl_pkg::SEL_SA;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

/* src/ftl_dp.sv */
// Flow table datapath: key and hash registers, entry memory, probe counters, result register.
module ftl_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ftl_pkg::dp_cmd_t                cmd,
    output ftl_pkg::dp_status_t             status,
    input  logic [ftl_pkg::ADDR_W-1:0]      source_address,
    input  logic [ftl_pkg::ADDR_W-1:0]      destination_address,
    input  logic [ftl_pkg::PORT_W-1:0]      source_port_number,
    input  logic [ftl_pkg::PORT_W-1:0]      destination_port_number,
    input  logic [ftl_pkg::PROTO_W-1:0]     protocol_number,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [ftl_pkg::SLOT_OUT_W-1:0]  slot_index,
    output logic [ftl_pkg::FLOW_W-1:0]      flow_number,
    output logic                            was_new,
    output logic                            table_full
);

    localparam int SLOT_W = $clog2(TABLE_DEPTH);

    ftl_pkg::entry_t              mem [TABLE_DEPTH];
    ftl_pkg::entry_t              rd_data_reg;
    ftl_pkg::entry_t              wr_data;

    logic [ftl_pkg::ADDR_W-1:0]   sa_reg, da_reg;
    logic [ftl_pkg::PORT_W-1:0]   sp_reg, dp_reg;
    logic [ftl_pkg::PROTO_W-1:0]  pr_reg;
    logic [SLOT_W-1:0]            hash_reg;
    logic [SLOT_W-1:0]            hash_next;
    logic [ftl_pkg::ADDR_W-1:0]   fold_field;
    logic [SLOT_W-1:0]            slot_reg;
    logic [SLOT_W-1:0]            probe_cnt_reg;
    logic [ftl_pkg::COUNT_W-1:0]  count_reg;
    logic                         out_valid_reg;
    logic [ftl_pkg::SLOT_OUT_W-1:0] slot_out_reg;
    logic [ftl_pkg::FLOW_W-1:0]   flow_out_reg;
    logic                         new_out_reg;
    logic                         full_out_reg;
    logic                         out_load;

    // Select the key field for this fold step
    always_comb
    begin
        case (cmd.hash_sel)
            ftl_pkg::SEL_SA: fold_field = sa_reg;
            ftl_pkg::SEL_DA: fold_field = da_reg;
            ftl_pkg::SEL_SP: fold_field = ftl_pkg::ADDR_W'(sp_reg);
            ftl_pkg::SEL_DP: fold_field = ftl_pkg::ADDR_W'(dp_reg);
            ftl_pkg::SEL_PR: fold_field = ftl_pkg::ADDR_W'(pr_reg);
            default:         fold_field = '0;
        endcase
    end

    // Fold only the low slot bits; higher hash bits never reach the slot
    assign hash_next = hash_reg * SLOT_W'(ftl_pkg::HASH_MULT) + fold_field[SLOT_W-1:0];

    // Build the entry written on insert, or an empty entry during clearing
    always_comb
    begin
        wr_data = '0;
        if (!cmd.clear)
        begin
            wr_data.valid                   = 1'b1;
            wr_data.source_address          = sa_reg;
            wr_data.destination_address     = da_reg;
            wr_data.source_port_number      = sp_reg;
            wr_data.destination_port_number = dp_reg;
            wr_data.protocol_number         = pr_reg;
            wr_data.flow_number             = count_reg[ftl_pkg::FLOW_W-1:0];
        end
    end

    // Entry memory: one write, one registered read at the current slot
    always_ff @(posedge clk)
    begin
        if (cmd.clear || cmd.insert)
        begin
            mem[slot_reg] <= wr_data;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[slot_reg];
        end
    end

    // Capture key, fold hash, count probes
    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            sa_reg   <= source_address;
            da_reg   <= destination_address;
            sp_reg   <= source_port_number;
            dp_reg   <= destination_port_number;
            pr_reg   <= protocol_number;
            hash_reg <= '0;
        end
        else if (cmd.hash_step)
        begin
            hash_reg <= hash_next;
        end
        if (cmd.seed)
        begin
            probe_cnt_reg <= '0;
        end
        else if (cmd.advance)
        begin
            probe_cnt_reg <= probe_cnt_reg + SLOT_W'(1);
        end
    end

    // Slot address, flow counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.seed)
            begin
                slot_reg <= hash_reg;
            end
            else if (cmd.clear || cmd.advance)
            begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
            if (cmd.insert)
            begin
                count_reg <= count_reg + ftl_pkg::COUNT_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_load = cmd.insert || cmd.hit || cmd.full;

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            slot_out_reg <= ftl_pkg::SLOT_OUT_W'(slot_reg);
            flow_out_reg <= count_reg[ftl_pkg::FLOW_W-1:0];
            new_out_reg  <= 1'b1;
            full_out_reg <= 1'b0;
        end
        else if (cmd.hit)
        begin
            slot_out_reg <= ftl_pkg::SLOT_OUT_W'(slot_reg);
            flow_out_reg <= rd_data_reg.flow_number;
            new_out_reg  <= 1'b0;
            full_out_reg <= 1'b0;
        end
        else if (cmd.full)
        begin
            slot_out_reg <= '0;
            flow_out_reg <= '0;
            new_out_reg  <= 1'b0;
            full_out_reg <= 1'b1;
        end
    end

    // Status back to the controller
    always_comb
    begin
        status.entry_valid = rd_data_reg.valid;
        status.key_hit     = (rd_data_reg.source_address == sa_reg)
                          && (rd_data_reg.destination_address == da_reg)
                          && (rd_data_reg.source_port_number == sp_reg)
                          && (rd_data_reg.destination_port_number == dp_reg)
                          && (rd_data_reg.protocol_number == pr_reg);
        status.probe_last  = (probe_cnt_reg == SLOT_W'(TABLE_DEPTH - 1));
        status.clear_last  = (slot_reg == SLOT_W'(TABLE_DEPTH - 1));
        status.out_free    = !out_valid_reg || result_ready;
    end

    assign result_valid = out_valid_reg;
    assign slot_index   = slot_out_reg;
    assign flow_number  = flow_out_reg;
    assign was_new      = new_out_reg;
    assign table_full   = full_out_reg;

endmodule

/* tb/tb_top.sv */
// Testbench for the five-tuple flow table: directed keys, then a random mix under stalls.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH   = 1024;
    localparam int DIRECTED_ROWS = 21;
    localparam int RANDOM_ITEMS  = 630;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam bit [63:0] FOLD_MULT = 64'd131;

    typedef struct packed {
        logic [ftl_pkg::ADDR_W-1:0]  source_address;
        logic [ftl_pkg::ADDR_W-1:0]  destination_address;
        logic [ftl_pkg::PORT_W-1:0]  source_port_number;
        logic [ftl_pkg::PORT_W-1:0]  destination_port_number;
        logic [ftl_pkg::PROTO_W-1:0] protocol_number;
    } flow_key_t;

    typedef struct packed {
        logic [ftl_pkg::SLOT_OUT_W-1:0] slot_index;
        logic [ftl_pkg::FLOW_W-1:0]     flow_number;
        logic                           was_new;
        logic                           table_full;
    } lookup_result_t;

    // One directed word: key, optional home-slot aim, optional pinned result
    typedef struct packed {
        flow_key_t      key;
        logic           aim;
        logic [9:0]     home;
        logic           pinned;
        lookup_result_t pinned_res;
    } directed_row_t;

    typedef enum int {MIX_FRESH, MIX_REVISIT, MIX_COLLIDE, MIX_NEAR, MIX_EDGE} mix_kind_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_CADENCE, RX_BURSTY} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ftl_key_if lookup_ch ();
    ftl_res_if result_ch ();

    flow_table_lookup_insert #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .lookup (lookup_ch),
        .result (result_ch)
    );

    // Predicted table contents
    logic           slot_used [TABLE_DEPTH];
    flow_key_t      slot_key  [TABLE_DEPTH];
    logic [9:0]     slot_flow [TABLE_DEPTH];
    logic [10:0]    next_flow;

    lookup_result_t pending_results [$];
    flow_key_t      seen_flows [$];
    int             mismatch_count = 0;
    int             cycle_count = 0;
    int             burst_left = 0;
    bit             hold_request = 1'b0;

    // Zero-family keys share home slot zero, so they stack up on slots 0..4
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{32'h0, 32'h0, 16'h0, 16'h0, 8'h0}, 1'b0, 10'd0, 1'b1,
          '{10'd0, 10'd0, 1'b1, 1'b0}},
        '{'{32'h0, 32'h0, 16'h0, 16'h0, 8'h0}, 1'b0, 10'd0, 1'b1,
          '{10'd0, 10'd0, 1'b0, 1'b0}},
        '{'{32'd1024, 32'h0, 16'h0, 16'h0, 8'h0}, 1'b0, 10'd0, 1'b1,
          '{10'd1, 10'd1, 1'b1, 1'b0}},
        '{'{32'h0, 32'd1024, 16'h0, 16'h0, 8'h0}, 1'b0, 10'd0, 1'b1,
          '{10'd2, 10'd2, 1'b1, 1'b0}},
        '{'{32'h0, 32'h0, 16'd1024, 16'h0, 8'h0}, 1'b0, 10'd0, 1'b1,
          '{10'd3, 10'd3, 1'b1, 1'b0}},
        '{'{32'h0, 32'h0, 16'h0, 16'd1024, 8'h0}, 1'b0, 10'd0, 1'b1,
          '{10'd4, 10'd4, 1'b1, 1'b0}},
        '{'{32'd1024, 32'h0, 16'h0, 16'h0, 8'h0}, 1'b0, 10'd0, 1'b1,
          '{10'd1, 10'd1, 1'b0, 1'b0}},
        '{'{32'h0, 32'h0, 16'h0, 16'd1024, 8'h0}, 1'b0, 10'd0, 1'b1,
          '{10'd4, 10'd4, 1'b0, 1'b0}},
        '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b0, 10'd0, 1'b0, '0},
        '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b0, 10'd0, 1'b0, '0},
        '{'{32'hFFFFFFFF, 32'h0, 16'h0, 16'h0, 8'h0}, 1'b0, 10'd0, 1'b0, '0},
        '{'{32'h0, 32'hFFFFFFFF, 16'h0, 16'h0, 8'h0}, 1'b0, 10'd0, 1'b0, '0},
        '{'{32'h0, 32'h0, 16'hFFFF, 16'h0, 8'h0}, 1'b0, 10'd0, 1'b0, '0},
        '{'{32'h0, 32'h0, 16'h0, 16'hFFFF, 8'h0}, 1'b0, 10'd0, 1'b0, '0},
        '{'{32'h0, 32'h0, 16'h0, 16'h0, 8'hFF}, 1'b0, 10'd0, 1'b0, '0},
        // same addresses and ports, TCP then UDP
        '{'{32'h0A000001, 32'hC0A80001, 16'd1234, 16'd80, 8'd6}, 1'b0, 10'd0, 1'b0, '0},
        '{'{32'h0A000001, 32'hC0A80001, 16'd1234, 16'd80, 8'd17}, 1'b0, 10'd0, 1'b0, '0},
        // three keys aimed at the last slot force the probe to wrap
        '{'{32'h11111111, 32'h22222222, 16'h3333, 16'h0, 8'h44}, 1'b1, 10'd1023, 1'b0, '0},
        '{'{32'h55555555, 32'h66666666, 16'h7777, 16'h0, 8'h88}, 1'b1, 10'd1023, 1'b0, '0},
        '{'{32'h99999999, 32'hAAAAAAAA, 16'hBBBB, 16'h0, 8'hCC}, 1'b1, 10'd1023, 1'b0, '0},
        '{'{32'h11111111, 32'h22222222, 16'h3333, 16'h0, 8'h44}, 1'b1, 10'd1023, 1'b0, '0}
    };

    always #1 clk = ~clk;

    // Fold the five fields into a 64-bit hash, wrapping
    function automatic logic [63:0] fold_hash(flow_key_t k);
        logic [63:0] h;
        h = '0;
        h = h * FOLD_MULT + 64'(k.source_address);
        h = h * FOLD_MULT + 64'(k.destination_address);
        h = h * FOLD_MULT + 64'(k.source_port_number);
        h = h * FOLD_MULT + 64'(k.destination_port_number);
        h = h * FOLD_MULT + 64'(k.protocol_number);
        return h;
    endfunction

    function automatic int home_of(flow_key_t k);
        return int'(fold_hash(k) % 64'(TABLE_DEPTH));
    endfunction

    // Walk the predicted table from the home slot; claim an empty slot on a miss
    function automatic lookup_result_t predict_lookup(flow_key_t k);
        int s;
        int n;
        lookup_result_t r;
        s = home_of(k);
        r = '0;
        r.table_full = 1'b1;
        for (n = 0; n < TABLE_DEPTH; n++)
        begin
            if (!slot_used[s])
            begin
                slot_used[s] = 1'b1;
                slot_key[s]  = k;
                slot_flow[s] = next_flow[9:0];
                r = '{ftl_pkg::SLOT_OUT_W'(s), next_flow[9:0], 1'b1, 1'b0};
                next_flow++;
                return r;
            end
            if (slot_key[s] == k)
            begin
                r = '{ftl_pkg::SLOT_OUT_W'(s), slot_flow[s], 1'b0, 1'b0};
                return r;
            end
            s = (s + 1) % TABLE_DEPTH;
        end
        return r;
    endfunction

    // Bias random words toward all zeros and all ones
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0: w = '0;
            1: w = '1;
            default: ;
        endcase
        return w;
    endfunction

    function automatic flow_key_t fresh_key();
        flow_key_t k;
        k.source_address          = pick_word();
        k.destination_address     = pick_word();
        k.source_port_number      = 16'(pick_word());
        k.destination_port_number = 16'(pick_word());
        k.protocol_number         = 8'(pick_word());
        return k;
    endfunction

    // Adjust the destination port until the key hashes to the target slot
    function automatic flow_key_t aim_at_slot(flow_key_t k, int target);
        flow_key_t probe;
        int i;
        probe = k;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            probe.destination_port_number = k.destination_port_number + 16'(i);
            if (home_of(probe) == target)
                return probe;
        end
        return k;
    endfunction

    // Idle the sender with junk on the payload
    task automatic pause_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            lookup_ch.valid                   <= 1'b0;
            lookup_ch.source_address          <= $urandom;
            lookup_ch.destination_address     <= $urandom;
            lookup_ch.source_port_number      <= 16'($urandom);
            lookup_ch.destination_port_number <= 16'($urandom);
            lookup_ch.protocol_number         <= 8'($urandom);
        end
    endtask

    // Hold valid until the word is taken, then record its expected result
    task automatic send_key(input flow_key_t k, input logic pinned,
                            input lookup_result_t pinned_res, output lookup_result_t predicted);
        @(negedge clk);
        lookup_ch.valid                   <= 1'b1;
        lookup_ch.source_address          <= k.source_address;
        lookup_ch.destination_address     <= k.destination_address;
        lookup_ch.source_port_number      <= k.source_port_number;
        lookup_ch.destination_port_number <= k.destination_port_number;
        lookup_ch.protocol_number         <= k.protocol_number;
        @(posedge clk);
        while (!lookup_ch.ready)
            @(posedge clk);
        predicted = predict_lookup(k);
        pending_results.push_back(pinned ? pinned_res : predicted);
        if (predicted.was_new)
            seen_flows.push_back(k);
    endtask

    // Send in bursts of random length, most of them after a random gap
    task automatic offer_key(input flow_key_t k, output lookup_result_t predicted);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                pause_cycles($urandom_range(1, 14));
        end
        burst_left--;
        send_key(k, 1'b0, '0, predicted);
    endtask

    // Drop valid and hold off until every expected result has come back
    task automatic wait_for_results();
        pause_cycles(1);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic flow_key_t pick_seen();
        return seen_flows[$urandom_range(0, seen_flows.size() - 1)];
    endfunction

    // Known key with one field nudged; a step of 1024 keeps the home slot
    function automatic flow_key_t near_miss(flow_key_t k);
        case ($urandom_range(0, 5))
            0: k.source_address          += 32'd1024;
            1: k.destination_address     += 32'd1024;
            2: k.source_port_number      += 16'd1024;
            3: k.destination_port_number += 16'd1024;
            4: k.protocol_number         ^= 8'(1 << $urandom_range(0, 7));
            default: k.source_address    ^= 32'(1) << $urandom_range(0, 31);
        endcase
        return k;
    endfunction

    // Reset, then stimulus phases
    initial
    begin
        lookup_result_t got;
        flow_key_t k;
        mix_kind_t kind;
        int pick;
        int i;

        lookup_ch.valid                   <= 1'b0;
        lookup_ch.source_address          <= '0;
        lookup_ch.destination_address     <= '0;
        lookup_ch.source_port_number      <= '0;
        lookup_ch.destination_port_number <= '0;
        lookup_ch.protocol_number         <= '0;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_flow[i] = '0;
        end
        next_flow = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words
        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            k = directed_rows[i].key;
            if (directed_rows[i].aim)
                k = aim_at_slot(k, int'(directed_rows[i].home));
            if ($urandom_range(0, 2) == 0)
                pause_cycles($urandom_range(1, 6));
            send_key(k, directed_rows[i].pinned, directed_rows[i].pinned_res, got);
        end
        wait_for_results();

        // Random mix of fresh keys, revisits, collisions, near misses and keys aimed near the end of the table
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                kind = MIX_FRESH;
            else if (pick < 65)
                kind = MIX_REVISIT;
            else if (pick < 80)
                kind = MIX_COLLIDE;
            else if (pick < 90)
                kind = MIX_NEAR;
            else
                kind = MIX_EDGE;
            case (kind)
                MIX_REVISIT: k = pick_seen();
                MIX_COLLIDE: k = aim_at_slot(fresh_key(), home_of(pick_seen()));
                MIX_NEAR:    k = near_miss(pick_seen());
                MIX_EDGE:    k = aim_at_slot(fresh_key(),
                                             $urandom_range(TABLE_DEPTH - 8, TABLE_DEPTH - 1));
                default:     k = fresh_key();
            endcase
            // Stall the result side for a long stretch while keys keep coming
            if (i == 200)
                hold_request = 1'b1;
            if (i == 420)
                wait_for_results();
            offer_key(k, got);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Receiver: ready patterns picked anew every segment, plus a long hold on request
    initial
    begin
        rx_mode_t mode;
        int seg_left;
        int stall_left;
        int hold_left;
        int tick;
        logic nxt;
        mode       = RX_OPEN;
        seg_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        tick       = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = rx_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                case (mode)
                    RX_COIN:    nxt = ($urandom_range(0, 9) < 7);
                    RX_CADENCE:
                    begin
                        tick++;
                        nxt = (tick % 5) != 0;
                    end
                    RX_BURSTY:
                    begin
                        if (stall_left > 0)
                        begin
                            stall_left--;
                            nxt = 1'b0;
                        end
                        else if ($urandom_range(0, 15) == 0)
                        begin
                            stall_left = $urandom_range(1, 12);
                            nxt = 1'b0;
                        end
                        else
                            nxt = 1'b1;
                    end
                    default:    nxt = 1'b1;
                endcase
            end
            result_ch.ready <= nxt;
        end
    end

    // Compare each taken result word with the oldest expectation
    always @(posedge clk)
    begin : result_check
        lookup_result_t got;
        lookup_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.slot_index  = result_ch.slot_index;
            got.flow_number = result_ch.flow_number;
            got.was_new     = result_ch.was_new;
            got.table_full  = result_ch.table_full;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result slot %0d flow %0d new %b full %b", $time,
                         got.slot_index, got.flow_number, got.was_new, got.table_full);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    $display("%0t: expected %0d/%0d/%b/%b, actual %0d/%0d/%b/%b",
                             $time, want.slot_index, want.flow_number, want.was_new,
                             want.table_full, got.slot_index, got.flow_number, got.was_new,
                             got.table_full);
                end
            end
        end
    end

    // Stop a hung run
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule

/* flow_table_lookup_insert.f */
src/ftl_pkg.sv
src/ftl_key_if.sv
src/ftl_res_if.sv
src/ftl_ctrl.sv
src/ftl_dp.sv
src/flow_table_lookup_insert.sv
tb/tb_top.sv
